// File: design/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and lookup functions for the base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int unsigned MaxRes     = 5;  // results one item can cause
  localparam int unsigned CntW       = 3;  // width of a result count
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [7:0] PadChar  = 8'h3D;
  localparam logic [0:0] RegMode  = 1'b0;  // word index of the mode register

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } result_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [CntW-1:0]      cnt;
  } job_t;

  // sextet value to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
        c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
        c = 8'h2B;
      end else begin
        c = 8'h2F;
      end
      return c;
    end
  endfunction

  // alphabet character to sextet value; ok low outside the alphabet
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    begin
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
        r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
        r = {1'b1, 6'd63};
      end
      return r;
    end
  endfunction

endpackage

// File: design/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// Accepts items, updates the bit buffer and message state, and packs every
// result the item causes into one job for the back end.
// ----------------------------------------------------------------------------
module b64c_front
  import b64c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  input  logic       clear_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       msg_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output job_t       q_job_o
);

  logic [11:0] buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  ph_q, ph_d;
  logic        pad_q, pad_d;
  logic        inv_q, inv_d;
  logic        accept;
  job_t        job;
  logic [CntW-1:0] n;
  logic [11:0] sh;
  logic [6:0]  sx;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    ph_d  = ph_q;
    pad_d = pad_q;
    inv_d = inv_q;
    job   = '0;
    n     = '0;
    sh    = '0;
    sx    = '0;
    if (mode_i == MODE_ENC) begin
      buf_d = {buf_q[3:0], in_byte_i};
      cnt_d = cnt_q + 4'd8;
      for (int k = 0; k < 2; k++) begin
        if (cnt_d >= 4'd6) begin
          sh = buf_d >> (cnt_d - 4'd6);
          job.res[n] = '{data: b64_char(sh[5:0]), kind: KIND_DATA};
          n     = n + 1'b1;
          ph_d  = ph_d + 2'd1;
          cnt_d = cnt_d - 4'd6;
        end
      end
      if (msg_last_i) begin
        if (cnt_d != 4'd0) begin
          sh = buf_d << (4'd6 - cnt_d);
          job.res[n] = '{data: b64_char(sh[5:0]), kind: KIND_DATA};
          n    = n + 1'b1;
          ph_d = ph_d + 2'd1;
        end
        // pad the group out to four characters
        for (int k = 0; k < 3; k++) begin
          if (ph_d != 2'd0) begin
            job.res[n] = '{data: PadChar, kind: KIND_DATA};
            n    = n + 1'b1;
            ph_d = ph_d + 2'd1;
          end
        end
      end
    end else begin
      if (!pad_q && !inv_q) begin
        sx = b64_sextet(in_byte_i);
        if (in_byte_i == PadChar) begin
          pad_d = 1'b1;
        end else if (!sx[6]) begin
          inv_d = 1'b1;
        end else begin
          buf_d = {buf_q[5:0], sx[5:0]};
          cnt_d = cnt_q + 4'd6;
          if (cnt_d >= 4'd8) begin
            sh = buf_d >> (cnt_d - 4'd8);
            job.res[n] = '{data: sh[7:0], kind: KIND_DATA};
            n     = n + 1'b1;
            cnt_d = cnt_d - 4'd8;
          end
        end
      end
    end
    if (msg_last_i) begin
      job.res[n] = '{data: 8'h00, kind: ((mode_i == MODE_DEC) && inv_d) ? KIND_BAD : KIND_OK};
      n = n + 1'b1;
    end
    job.cnt = n;
  end

  assign q_push_o = accept && (job.cnt != '0);
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      ph_q  <= '0;
      pad_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (clear_i || (accept && msg_last_i)) begin
      // end of message or mode write: drop all message state
      buf_q <= '0;
      cnt_q <= '0;
      ph_q  <= '0;
      pad_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (accept) begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      ph_q  <= ph_d;
      pad_q <= pad_d;
      inv_q <= inv_d;
    end
  end

endmodule

// File: design/b64c_fifo.sv
// ----------------------------------------------------------------------------
// b64c_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module b64c_fifo
  import b64c_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [FillW-1:0] fill_q;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == FillW'(Depth));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// File: design/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// Walks the results of the head job, one per cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module b64c_back
  import b64c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       run_last_o
);

  logic            valid_q;
  logic [7:0]      byte_q;
  kind_e           kind_q;
  logic            last_q;
  logic [CntW-1:0] idx_q;
  logic            load;
  logic            final_res;

  assign load      = (!valid_q || out_ready_i) && !empty_i;
  assign final_res = (idx_q == head_i.cnt - 1'b1);
  assign pop_o     = load && final_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= final_res ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.res[idx_q].data;
      kind_q <= head_i.res[idx_q].kind;
      last_q <= final_res;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign kind_o      = kind_q;
  assign run_last_o  = last_q;

endmodule

// File: design/base64_codec_unit.sv
// ----------------------------------------------------------------------------
// base64_codec_unit
// Base64 encoder/decoder with an APB mode register.
// ----------------------------------------------------------------------------
// Usage:
//   Set mode over APB (word 0, bit 0): 0 encodes bytes into base64 characters,
//   1 decodes characters into bytes. A mode write drops any message underway.
//   Items enter on in_valid_i/in_ready_o with in_byte_i and msg_last_i; each
//   message ends with a status result (kind 1 ok, kind 2 invalid character).
//   Results leave on out_valid_o/out_ready_i; run_last_o marks the final
//   result of an item. An item causes zero to five results.
//   With the queue empty, the first result of an item is written into the job
//   queue and then loaded into the output register.
//   Throughput: one item per cycle into the job queue while it is not full,
//   one result per cycle out of the result walker while out_ready_i is set;
//   the output port sets the pace. A byte encodes to one or two characters
//   plus padding and status at message end; a character gives at most a byte.
//   A stalled receiver holds the output register; the queue then fills and
//   in_ready_o drops until a job drains.
//   Reset clears mode to encode and all message state.
// ----------------------------------------------------------------------------
module base64_codec_unit
  import b64c_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             msg_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       kind_o,
  output logic             run_last_o
);

  logic mode_q;
  logic cfg_wr;
  logic q_push, q_pop, q_empty, q_full;
  job_t q_in, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrW-1] == RegMode);
  assign prdata = (paddr[AddrW-1] == RegMode) ? {{(DataW-1){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  b64c_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .clear_i    (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .msg_last_i (msg_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_in)
  );

  b64c_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_in),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  b64c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .run_last_o  (run_last_o)
  );

endmodule
